// File: rtl/hakd_pkg.sv
// ----------------------------------------------------------------------------
// hakd_pkg: shared types and constants for the heatmap argmax keypoint decoder
// Control/status structs, register indexes, output codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package hakd_pkg;

   localparam int MAX_DIM_DEFAULT    = 256;
   localparam int SCORE_BITS_DEFAULT = 16;

   // pixel index width, also the quotient width of every division pass
   localparam int IDX_BITS  = 16;
   localparam int DIM_BITS  = 9;
   localparam int NORM_BITS = 17;
   localparam int MARK_BITS = 2;
   localparam int CSR_BITS  = 2;

   localparam logic [CSR_BITS-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_INDEX_MODE = 2'd2;

   localparam logic [DIM_BITS-1:0] DIM_RESET = 9'd64;

   // Q8.8 -1.0
   localparam int BEST_RESET_VAL = -256;

   localparam logic signed [NORM_BITS-1:0] NORM_NONE = 17'sh10000;
   localparam logic [IDX_BITS-1:0]         NORM_SAT  = 16'hFFFF;
   localparam logic signed [MARK_BITS-1:0] MARK_FOUND = 2'sb01;
   localparam logic signed [MARK_BITS-1:0] MARK_NONE  = 2'sb11;

   typedef struct packed {
      logic scan_en;     // accepted pixel in scan mode
      logic scan_clear;  // accepted last pixel: restart the scan
      logic load_idx;    // start index / width pass
      logic set_bad;     // result is the invisible / unknown code
      logic load_x;      // start column / width pass
      logic load_y;      // start row / height pass
      logic step;        // one divider iteration
      logic div_h;       // divide by height
      logic out_load;    // move the result into the output register
   } hakd_cmd_type;

   typedef struct packed {
      logic index_mode;
      logic row_sat;     // row not below height
   } hakd_status_type;

endpackage

`default_nettype wire

// File: rtl/hakd_ctrl.sv
// ----------------------------------------------------------------------------
// hakd_ctrl: sequencer of the keypoint decoder
// Accepts items, runs up to three divider passes and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hakd_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_keypoint_visible,
   input  wire logic                      req_roi_known,
   input  wire logic                      req_last_pixel,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   input  hakd_pkg::hakd_status_type      status,
   output hakd_pkg::hakd_cmd_type         cmd
);
   import hakd_pkg::*;

   localparam int CNT_BITS = $clog2(IDX_BITS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIVQ = 3'd1;
   localparam logic [2:0] S_LDX  = 3'd2;
   localparam logic [2:0] S_DIVX = 3'd3;
   localparam logic [2:0] S_LDY  = 3'd4;
   localparam logic [2:0] S_DIVY = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept, emit, ok, last_step, dividing;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign emit      = status.index_mode || req_last_pixel;
   assign ok        = req_keypoint_visible && req_roi_known;
   assign last_step = (cnt_ff == CNT_BITS'(IDX_BITS - 1));
   assign dividing  = (state_ff == S_DIVQ) || (state_ff == S_DIVX) || (state_ff == S_DIVY);

   always_comb begin
      cmd            = '0;
      cmd.scan_en    = accept && !status.index_mode;
      cmd.scan_clear = accept && !status.index_mode && req_last_pixel;
      cmd.load_idx   = accept && emit && ok;
      cmd.set_bad    = accept && emit && !ok;
      cmd.load_x     = (state_ff == S_LDX);
      cmd.load_y     = (state_ff == S_LDY);
      cmd.step       = dividing;
      cmd.div_h      = (state_ff == S_DIVY);
      cmd.out_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load_idx) state_in = S_DIVQ;
            else if (cmd.set_bad) state_in = S_DONE;
         end
         S_DIVQ: if (last_step) state_in = S_LDX;
         S_LDX:  state_in = S_DIVX;
         S_DIVX: if (last_step) state_in = S_LDY;
         S_LDY:  state_in = status.row_sat ? S_DONE : S_DIVY;
         S_DIVY: if (last_step) state_in = S_DONE;
         S_DONE: if (cmd.out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign cnt_in       = dividing ? cnt_ff + 1'b1 : '0;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/hakd_datapath.sv
// ----------------------------------------------------------------------------
// hakd_datapath: argmax tracker, registers, shared divider, result register
// One restoring divider serves index/width, column/width and row/height.
// ----------------------------------------------------------------------------
`default_nettype none

module hakd_datapath #(
   parameter int MAX_DIM    = hakd_pkg::MAX_DIM_DEFAULT,
   parameter int SCORE_BITS = hakd_pkg::SCORE_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [hakd_pkg::CSR_BITS-1:0]          csr_index,
   input  wire logic [hakd_pkg::DIM_BITS-1:0]          csr_data,
   input  wire logic signed [SCORE_BITS-1:0]           req_score,
   input  wire logic [hakd_pkg::IDX_BITS-1:0]          req_given_index,
   input  hakd_pkg::hakd_cmd_type                      cmd,
   output hakd_pkg::hakd_status_type                   status,
   output logic signed [hakd_pkg::NORM_BITS-1:0]       rsp_x_norm,
   output logic signed [hakd_pkg::NORM_BITS-1:0]       rsp_y_norm,
   output logic signed [hakd_pkg::MARK_BITS-1:0]       rsp_mark
);
   import hakd_pkg::*;

   localparam int DV_BITS   = $clog2(MAX_DIM + 1);
   localparam int BEST_BITS = (SCORE_BITS < 10) ? 10 : SCORE_BITS;

   logic [DIM_BITS-1:0] width_ff, height_ff;
   logic                index_mode_ff;

   logic signed [BEST_BITS-1:0] best_ff, best_in, score_ext;
   logic [IDX_BITS-1:0]         best_idx_ff, best_idx_in, best_idx_new;
   logic [IDX_BITS-1:0]         count_ff, count_in;
   logic                        better;

   logic [DV_BITS-1:0]  div_w, div_h, divisor;
   logic [DV_BITS-1:0]  rem_ff, rem_in, rem_step;
   logic [IDX_BITS-1:0] quo_ff, quo_in;
   logic [DV_BITS:0]    trial;
   logic                fits;
   logic [IDX_BITS-1:0] row_ff, x_ff;
   logic                bad_ff, y_sat_ff;

   logic signed [NORM_BITS-1:0] x_out_ff, y_out_ff;
   logic signed [MARK_BITS-1:0] mark_out_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_RESET;
         height_ff     <= DIM_RESET;
         index_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAP_WIDTH:  width_ff      <= csr_data;
            CSR_MAP_HEIGHT: height_ff     <= csr_data;
            CSR_INDEX_MODE: index_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp dimensions: zero counts as one, above MAX_DIM counts as MAX_DIM
   always_comb begin
      if (width_ff == '0) div_w = DV_BITS'(1);
      else if (32'(width_ff) > 32'(MAX_DIM)) div_w = DV_BITS'(MAX_DIM);
      else div_w = DV_BITS'(width_ff);
      if (height_ff == '0) div_h = DV_BITS'(1);
      else if (32'(height_ff) > 32'(MAX_DIM)) div_h = DV_BITS'(MAX_DIM);
      else div_h = DV_BITS'(height_ff);
   end

   // argmax scan: strictly greater wins, so the first maximum is kept
   assign score_ext    = BEST_BITS'(req_score);
   assign better       = (score_ext > best_ff);
   assign best_idx_new = better ? count_ff : best_idx_ff;

   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      count_in    = count_ff;
      if (cmd.scan_clear) begin
         best_in     = BEST_BITS'(BEST_RESET_VAL);
         best_idx_in = '0;
         count_in    = '0;
      end else if (cmd.scan_en) begin
         if (better) best_in = score_ext;
         best_idx_in = best_idx_new;
         count_in    = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff     <= BEST_BITS'(BEST_RESET_VAL);
         best_idx_ff <= '0;
         count_ff    <= '0;
      end else begin
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
         count_ff    <= count_in;
      end
   end

   // restoring divider: partial remainder stays below the divisor
   assign divisor  = cmd.div_h ? div_h : div_w;
   assign trial    = {rem_ff, quo_ff[IDX_BITS-1]};
   assign fits     = (trial >= {1'b0, divisor});
   assign rem_step = fits ? DV_BITS'(trial - {1'b0, divisor}) : DV_BITS'(trial);

   assign status.index_mode = index_mode_ff;
   assign status.row_sat    = (32'(row_ff) >= 32'(div_h));

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.load_idx) begin
         rem_in = '0;
         quo_in = index_mode_ff ? req_given_index : best_idx_new;
      end else if (cmd.load_x) begin
         // remainder already holds the column
         quo_in = '0;
      end else if (cmd.load_y) begin
         rem_in = DV_BITS'(row_ff);
         quo_in = '0;
      end else if (cmd.step) begin
         rem_in = rem_step;
         quo_in = {quo_ff[IDX_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load_x) row_ff <= quo_ff;
      if (cmd.load_y) begin
         x_ff     <= quo_ff;
         y_sat_ff <= status.row_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_ff <= 1'b0;
      end else if (cmd.set_bad) begin
         bad_ff <= 1'b1;
      end else if (cmd.load_idx) begin
         bad_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (bad_ff) begin
            x_out_ff    <= NORM_NONE;
            y_out_ff    <= NORM_NONE;
            mark_out_ff <= MARK_NONE;
         end else begin
            x_out_ff    <= signed'({1'b0, x_ff});
            y_out_ff    <= y_sat_ff ? signed'({1'b0, NORM_SAT}) : signed'({1'b0, quo_ff});
            mark_out_ff <= MARK_FOUND;
         end
      end
   end

   assign rsp_x_norm = x_out_ff;
   assign rsp_y_norm = y_out_ff;
   assign rsp_mark   = mark_out_ff;

endmodule

`default_nettype wire

// File: rtl/heatmap_argmax_keypoint_decode.sv
// ----------------------------------------------------------------------------
// heatmap_argmax_keypoint_decode: keypoint location from a heatmap channel
// Tracks the argmax of a pixel stream (or takes a given index) and returns
// the peak column/width and row/height as Q.16 fractions with a found mark.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  req     | req_valid/stall    | score, given_index, visible, roi, last_pixel
//  rsp     | rsp_valid/stall    | x_norm, y_norm, mark
//  csr     | csr_valid/ready    | csr_index, csr_data
//
//  Scan pixels without last_pixel take one cycle each while req_stall is low.
//  A visible keypoint with a known roi holds the input through three passes
//  of the single shared restoring divider plus the load and handoff states;
//  one pass fewer if the row saturates, none if the keypoint is invalid.
//  A pending result waits in the output register while pixels keep flowing.
//  Synchronous reset restores the configuration and control state and clears
//  the scan; csr is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module heatmap_argmax_keypoint_decode #(
   parameter int MAX_DIM    = hakd_pkg::MAX_DIM_DEFAULT,
   parameter int SCORE_BITS = hakd_pkg::SCORE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [SCORE_BITS-1:0]        req_score,
   input  wire logic [hakd_pkg::IDX_BITS-1:0]       req_given_index,
   input  wire logic                                req_keypoint_visible,
   input  wire logic                                req_roi_known,
   input  wire logic                                req_last_pixel,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [hakd_pkg::NORM_BITS-1:0]    rsp_x_norm,
   output logic signed [hakd_pkg::NORM_BITS-1:0]    rsp_y_norm,
   output logic signed [hakd_pkg::MARK_BITS-1:0]    rsp_mark,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [hakd_pkg::CSR_BITS-1:0]       csr_index,
   input  wire logic [hakd_pkg::DIM_BITS-1:0]       csr_data
);
   import hakd_pkg::*;

   hakd_cmd_type    cmd;
   hakd_status_type status;

   assign csr_ready = 1'b1;

   hakd_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_keypoint_visible (req_keypoint_visible),
      .req_roi_known        (req_roi_known),
      .req_last_pixel       (req_last_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .status               (status),
      .cmd                  (cmd)
   );

   hakd_datapath #(
      .MAX_DIM    (MAX_DIM),
      .SCORE_BITS (SCORE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_score       (req_score),
      .req_given_index (req_given_index),
      .cmd             (cmd),
      .status          (status),
      .rsp_x_norm      (rsp_x_norm),
      .rsp_y_norm      (rsp_y_norm),
      .rsp_mark        (rsp_mark)
   );

endmodule

`default_nettype wire
